### design/dsw_pkg.sv
package dsw_pkg;

    localparam int MAX_TARGET = 64;
    localparam int MAX_FACES  = 64;
    localparam int MAX_DICE   = 64;

    localparam int FIELD_W = 7;
    localparam int COUNT_W = 64;
    localparam int NUM_CELLS = MAX_TARGET + 1;

    localparam logic [FIELD_W-1:0] MAX_TARGET_F = FIELD_W'(MAX_TARGET);
    localparam logic [FIELD_W-1:0] MAX_FACES_F  = FIELD_W'(MAX_FACES);
    localparam logic [FIELD_W-1:0] MAX_DICE_F   = FIELD_W'(MAX_DICE);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_LOAD,
        CELL_STEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     shift_only;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_LOAD,
        ST_STEP,
        ST_RLOAD,
        ST_READ,
        ST_FIN
    } t_state;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    endfunction

endpackage

### design/dsw_cell.sv
module dsw_cell
    import dsw_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_base,
    input  logic [COUNT_W-1:0] i_sh,
    output logic [COUNT_W-1:0] o_sh
);

    logic [COUNT_W-1:0] r_row;
    logic [COUNT_W-1:0] r_sh;
    logic [COUNT_W-1:0] n_row;
    logic [COUNT_W-1:0] n_sh;

    always_comb begin
        n_row = r_row;
        n_sh  = r_sh;
        case (i_ctl.op)
            CELL_INIT: begin
                n_row = i_base ? COUNT_W'(1) : '0;
                n_sh  = '0;
            end
            CELL_LOAD: begin
                n_row = '0;
                n_sh  = r_row;
            end
            CELL_STEP: begin
                n_sh = i_sh;
                if (!i_ctl.shift_only) begin
                    n_row = sat_add(r_row, i_sh);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_sh  <= n_sh;
    end

    assign o_sh = r_sh;

endmodule

### design/dsw_row.sv
module dsw_row
    import dsw_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    output logic [COUNT_W-1:0] o_tail
);

    logic [COUNT_W-1:0] w_sh [NUM_CELLS+1];

    assign w_sh[0] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        dsw_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_base (g == 0),
            .i_sh   (w_sh[g]),
            .o_sh   (w_sh[g+1])
        );
    end

    assign o_tail = w_sh[NUM_CELLS];

endmodule

### design/dice_sum_way_counter_unit.sv
// channel | valid       | stall        | payload
// in      | i_in_valid  | o_in_stall   | i_faces, i_dice, i_target
// out     | o_out_valid | i_out_stall  | o_way_count, o_saturated
// one item at a time; a query takes an init step, a load step and one pass of the cell chain
// per face value for each die, then a load of the row and the final shift-out of the result
// an out of range query goes straight to the result; the next item is taken once the result is registered
// i_rst_n is synchronous and clears the controller and the output valid
// a new item is taken while the previous result still waits under i_out_stall
module dice_sum_way_counter_unit
    import dsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FIELD_W-1:0] i_faces,
    input  logic [FIELD_W-1:0] i_dice,
    input  logic [FIELD_W-1:0] i_target,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COUNT_W-1:0] o_way_count,
    output logic               o_saturated
);

    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_faces, r_dice, r_target;
    logic [FIELD_W-1:0] r_die, n_die;
    logic [FIELD_W-1:0] r_k, n_k;
    logic               r_oor, n_oor;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_way_count;
    logic               r_saturated;
    logic               w_accept;
    logic               w_out_free;
    logic               w_die_last;
    logic [FIELD_W-1:0] w_read_len;
    t_cell_ctl          w_ctl;
    logic [COUNT_W-1:0] w_tail;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_die_last = (r_die == r_dice);
    assign w_read_len = MAX_TARGET_F - r_target;

    always_comb begin
        n_state = r_state;
        n_die   = r_die;
        n_k     = r_k;
        n_oor   = r_oor;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_oor   = (i_faces > MAX_FACES_F) || (i_dice > MAX_DICE_F) ||
                              (i_target > MAX_TARGET_F);
                    n_state = n_oor ? ST_FIN : ST_INIT;
                end
            end
            ST_INIT: begin
                n_die   = FIELD_W'(1);
                n_state = (r_dice == '0) ? ST_RLOAD : ST_LOAD;
            end
            ST_LOAD: begin
                n_k = '0;
                if (r_faces != '0) begin
                    n_state = ST_STEP;
                end else if (w_die_last) begin
                    n_state = ST_RLOAD;
                end else begin
                    n_die = r_die + FIELD_W'(1);
                end
            end
            ST_STEP: begin
                n_k = r_k + FIELD_W'(1);
                if (n_k == r_faces) begin
                    if (w_die_last) begin
                        n_state = ST_RLOAD;
                    end else begin
                        n_die   = r_die + FIELD_W'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_RLOAD: begin
                n_k     = '0;
                n_state = (w_read_len == '0) ? ST_FIN : ST_READ;
            end
            ST_READ: begin
                n_k = r_k + FIELD_W'(1);
                if (n_k == w_read_len) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl.op         = CELL_HOLD;
        w_ctl.shift_only = 1'b0;
        unique case (r_state)
            ST_INIT:  w_ctl.op = CELL_INIT;
            ST_LOAD:  w_ctl.op = CELL_LOAD;
            ST_STEP:  w_ctl.op = CELL_STEP;
            ST_RLOAD: w_ctl.op = CELL_LOAD;
            ST_READ: begin
                w_ctl.op         = CELL_STEP;
                w_ctl.shift_only = 1'b1;
            end
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_die <= n_die;
        r_k   <= n_k;
        r_oor <= n_oor;
        if (w_accept) begin
            r_faces  <= i_faces;
            r_dice   <= i_dice;
            r_target <= i_target;
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_way_count <= r_oor ? '0 : w_tail;
            r_saturated <= !r_oor && (w_tail == {COUNT_W{1'b1}});
        end
    end

    dsw_row u_row (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_tail (w_tail)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_way_count = r_way_count;
    assign o_saturated = r_saturated;

endmodule

### design/dsw_checker.sv
module dsw_checker
    import dsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [COUNT_W-1:0] i_way_count,
    input  logic               i_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_way_count))
        else $error("stalled result changed");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> (i_way_count == {COUNT_W{1'b1}}))
        else $error("saturated flag without all-ones count");

    a_max_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_way_count == {COUNT_W{1'b1}}) |-> i_saturated)
        else $error("all-ones count without saturated flag");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("item taken while previous query still running");

endmodule

bind dice_sum_way_counter_unit dsw_checker u_dsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_way_count (o_way_count),
    .i_saturated (o_saturated)
);

### sim/way_count_checker.sv
`timescale 1ns / 100ps

module way_count_checker
    import dsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [FIELD_W-1:0] i_faces,
    input  logic [FIELD_W-1:0] i_dice,
    input  logic [FIELD_W-1:0] i_target,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [COUNT_W-1:0] i_way_count,
    input  logic               i_saturated,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [COUNT_W-1:0] way_count;
        logic               saturated;
    } t_way_result;

    t_way_result expected_ways_q[$];
    int          fail_total;

    function automatic t_way_result count_ways(input logic [FIELD_W-1:0] faces,
                                               input logic [FIELD_W-1:0] dice,
                                               input logic [FIELD_W-1:0] target);
        logic [COUNT_W-1:0] prev_row [NUM_CELLS];
        logic [COUNT_W-1:0] next_row [NUM_CELLS];
        logic [COUNT_W:0]   wide;
        logic [COUNT_W-1:0] acc;
        t_way_result        res;
        res.way_count = '0;
        res.saturated = 1'b0;
        if (faces > MAX_FACES_F || dice > MAX_DICE_F || target > MAX_TARGET_F) begin
            return res;
        end
        for (int s = 0; s < NUM_CELLS; s++) begin
            prev_row[s] = '0;
            next_row[s] = '0;
        end
        prev_row[0] = COUNT_W'(1);
        for (int d = 1; d <= int'(dice); d++) begin
            next_row[0] = '0;
            for (int s = 1; s <= int'(target); s++) begin
                acc = '0;
                for (int k = 1; k <= int'(faces) && k <= s; k++) begin
                    // saturating add
                    wide = {1'b0, acc} + {1'b0, prev_row[s-k]};
                    acc  = wide[COUNT_W] ? '1 : wide[COUNT_W-1:0];
                end
                next_row[s] = acc;
            end
            prev_row = next_row;
        end
        res.way_count = prev_row[target];
        res.saturated = &prev_row[target];
        return res;
    endfunction

    initial begin
        fail_total = 0;
    end

    always @(posedge i_clk) begin
        t_way_result want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_ways_q.size() == 0) begin
                    $display("%0t: unexpected item way_count %0d saturated %0b",
                             $time, i_way_count, i_saturated);
                    fail_total++;
                end else begin
                    want = expected_ways_q.pop_front();
                    if (i_way_count !== want.way_count) begin
                        $display("%0t: way_count expected %0d actual %0d",
                                 $time, want.way_count, i_way_count);
                        fail_total++;
                    end
                    if (i_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.saturated, i_saturated);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_ways_q.push_back(count_ways(i_faces, i_dice, i_target));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_ways_q.size();
    end

endmodule

### sim/dice_sum_way_counter_unit_test.sv
`timescale 1ns / 100ps

module dice_sum_way_counter_unit_test;
    import dsw_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [FIELD_W-1:0] i_faces;
    logic [FIELD_W-1:0] i_dice;
    logic [FIELD_W-1:0] i_target;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [COUNT_W-1:0] o_way_count;
    logic               o_saturated;

    int fail_count;
    int pending_count;
    int queries_sent;
    bit hold_done;

    dice_sum_way_counter_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_faces     (i_faces),
        .i_dice      (i_dice),
        .i_target    (i_target),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_way_count (o_way_count),
        .o_saturated (o_saturated)
    );

    way_count_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_faces      (i_faces),
        .i_dice       (i_dice),
        .i_target     (i_target),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_way_count  (o_way_count),
        .i_saturated  (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    task automatic send_query(input logic [FIELD_W-1:0] faces,
                              input logic [FIELD_W-1:0] dice,
                              input logic [FIELD_W-1:0] target,
                              input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_faces    <= faces;
        i_dice     <= dice;
        i_target   <= target;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queries_sent++;
    endtask

    // result side back-pressure, with one long hold to fill the block
    initial begin
        int len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && queries_sent >= 30) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (15000) @(posedge i_clk);
            end else begin
                len = pick_gap();
                if (len > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (len) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                len = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 6);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    initial begin
        int                 mode;
        logic [FIELD_W-1:0] f;
        logic [FIELD_W-1:0] d;
        logic [FIELD_W-1:0] t;
        queries_sent = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_faces     <= '0;
        i_dice      <= '0;
        i_target    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero dice, zero faces, zero target, then small queries
        send_query(7'd0, 7'd0, 7'd0, pick_gap());
        send_query(7'd5, 7'd0, 7'd3, pick_gap());
        send_query(7'd0, 7'd3, 7'd5, pick_gap());
        send_query(7'd6, 7'd3, 7'd0, pick_gap());
        send_query(7'd1, 7'd1, 7'd1, pick_gap());
        send_query(7'd6, 7'd2, 7'd7, pick_gap());
        send_query(7'd3, 7'd10, 7'd20, pick_gap());
        // full size corners
        send_query(7'd64, 7'd64, 7'd64, pick_gap());
        send_query(7'd64, 7'd64, 7'd63, pick_gap());
        send_query(7'd64, 7'd1, 7'd64, pick_gap());
        send_query(7'd64, 7'd2, 7'd64, pick_gap());
        send_query(7'd64, 7'd32, 7'd64, pick_gap());
        send_query(7'd1, 7'd64, 7'd64, pick_gap());
        send_query(7'd2, 7'd32, 7'd64, pick_gap());
        send_query(7'd64, 7'd16, 7'd48, pick_gap());
        // out of range fields
        send_query(7'd65, 7'd1, 7'd1, pick_gap());
        send_query(7'd127, 7'd1, 7'd1, pick_gap());
        send_query(7'd1, 7'd65, 7'd1, pick_gap());
        send_query(7'd1, 7'd127, 7'd127, pick_gap());
        send_query(7'd1, 7'd1, 7'd65, pick_gap());
        send_query(7'd127, 7'd127, 7'd127, pick_gap());

        for (int i = 0; i < 120; i++) begin
            mode = $urandom_range(0, 99);
            if (mode < 75) begin
                f = FIELD_W'($urandom_range(0, 8));
                d = FIELD_W'($urandom_range(0, 8));
                t = FIELD_W'($urandom_range(0, 40));
            end else if (mode < 85) begin
                f = FIELD_W'($urandom_range(0, 64));
                d = FIELD_W'($urandom_range(0, 64));
                t = FIELD_W'($urandom_range(0, 64));
            end else begin
                f = FIELD_W'($urandom_range(0, 127));
                d = FIELD_W'($urandom_range(0, 127));
                t = FIELD_W'($urandom_range(0, 127));
            end
            send_query(f, d, t, ((i / 20) % 2 == 1) ? 0 : pick_gap());
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4300) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("dice_sum_way_counter_unit: match");
        end else begin
            $display("dice_sum_way_counter_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("dice_sum_way_counter_unit: mismatch");
        $finish;
    end

endmodule
